>>> hdl/char_lcd_write_sequencer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the character LCD write sequencer
// Shared property forms, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_WRITE_SEQUENCER_MACROS_SVH
`define CHAR_LCD_WRITE_SEQUENCER_MACROS_SVH

// Same-cycle implication.
`define LCDWS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LCDWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/lcdws_pkg.sv
// ----------------------------------------------------------------------------
// lcdws_pkg
// Types and constants shared by the character LCD write sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdws_pkg;

  localparam int COLUMNS = 16;

  localparam logic [1:0] KIND_COMMAND = 2'd0;
  localparam logic [1:0] KIND_CHAR    = 2'd1;
  localparam logic [1:0] KIND_CURSOR  = 2'd2;
  localparam logic [1:0] KIND_NUMBER  = 2'd3;

  localparam logic [1:0] REG_FOUR_BIT_MODE = 2'd0;
  localparam logic [1:0] REG_LINE_ONE_BASE = 2'd1;
  localparam logic [1:0] REG_LINE_TWO_BASE = 2'd2;

  localparam logic [7:0] LINE_ONE_BASE_RESET = 8'd128;
  localparam logic [7:0] LINE_TWO_BASE_RESET = 8'd192;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;

  // x / 10 == (x * 0xCCCD) >> 19 for every 16-bit x.
  localparam logic [15:0] DIV10_RECIP = 16'hCCCD;
  localparam int          DIV10_SHIFT = 19;

  localparam int MAX_DIGITS = 5;
  localparam int DIGIT_IW   = $clog2(MAX_DIGITS);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         byte_value;
    logic [7:0]         line_index;
    logic [7:0]         column_index;
    logic signed [15:0] number_value;
  } item_t;

  typedef struct packed {
    logic       strobe_res;
    logic       register_select;
    logic [7:0] bus_data;
    logic       range_error;
    logic       last;
  } result_t;

  // One byte for the bus, or a status-only error entry when strobe is low.
  typedef struct packed {
    logic       strobe;
    logic       rs;
    logic [7:0] data;
    logic       err;
    logic       last;
  } byte_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

`default_nettype wire

>>> hdl/lcdws_fifo.sv
// ----------------------------------------------------------------------------
// lcdws_fifo
// Short byte queue between the request front end and the strobe back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdws_fifo (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire lcdws_pkg::byte_entry_t push_data,
  input  wire logic                  pop,
  output lcdws_pkg::byte_entry_t     head,
  output lcdws_pkg::fifo_status_t    status
);

  lcdws_pkg::byte_entry_t entries [lcdws_pkg::FIFO_DEPTH];
  logic [lcdws_pkg::FIFO_AW-1:0] wr_ptr;
  logic [lcdws_pkg::FIFO_AW-1:0] rd_ptr;
  logic [lcdws_pkg::FIFO_AW:0]   count;

  assign status.full  = (count == (lcdws_pkg::FIFO_AW+1)'(lcdws_pkg::FIFO_DEPTH));
  assign status.empty = (count == '0);
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/lcdws_front.sv
// ----------------------------------------------------------------------------
// lcdws_front
// Accepts requests, classifies them and queues the bytes they produce.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdws_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire lcdws_pkg::item_t      item,
  input  wire logic [7:0]            line_one_base,
  input  wire logic [7:0]            line_two_base,
  input  wire lcdws_pkg::fifo_status_t fifo_status,
  output logic                       busy,
  output logic                       push,
  output lcdws_pkg::byte_entry_t     push_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_SIGN,
    S_DIG
  } state_t;

  state_t state;

  logic [15:0] mag;
  logic        neg;
  logic [3:0]  digits [lcdws_pkg::MAX_DIGITS];
  logic [lcdws_pkg::DIGIT_IW-1:0] ndig;
  logic [lcdws_pkg::DIGIT_IW-1:0] idx;

  logic        accept;
  logic [31:0] prod;
  logic [15:0] quot;
  logic [15:0] rem;
  logic        cursor_bad;
  logic [7:0]  cursor_addr;
  logic [15:0] raw;

  assign busy   = (state != S_IDLE) || fifo_status.full;
  assign accept = start && !busy;
  assign raw    = 16'(item.number_value);

  // One decimal digit per cycle through a reciprocal multiply.
  assign prod = {16'b0, mag} * {16'b0, lcdws_pkg::DIV10_RECIP};
  assign quot = 16'(prod >> lcdws_pkg::DIV10_SHIFT);
  assign rem  = mag - {quot[12:0], 3'b000} - {quot[14:0], 1'b0};

  assign cursor_bad  = (item.line_index > 8'd1) ||
                       (item.column_index >= 8'(lcdws_pkg::COLUMNS));
  assign cursor_addr = ((item.line_index == 8'd0) ? line_one_base : line_two_base) +
                       item.column_index;

  always_comb begin
    push      = 1'b0;
    push_data = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (item.kind)
            lcdws_pkg::KIND_COMMAND: begin
              push      = 1'b1;
              push_data = '{strobe: 1'b1, rs: 1'b0, data: item.byte_value,
                            err: 1'b0, last: 1'b1};
            end
            lcdws_pkg::KIND_CHAR: begin
              push      = 1'b1;
              push_data = '{strobe: 1'b1, rs: 1'b1, data: item.byte_value,
                            err: 1'b0, last: 1'b1};
            end
            lcdws_pkg::KIND_CURSOR: begin
              push = 1'b1;
              if (cursor_bad) begin
                push_data = '{strobe: 1'b0, rs: 1'b0, data: 8'd0, err: 1'b1, last: 1'b1};
              end else begin
                push_data = '{strobe: 1'b1, rs: 1'b0, data: cursor_addr,
                              err: 1'b0, last: 1'b1};
              end
            end
            default: begin
              push = 1'b0;
            end
          endcase
        end
      end
      S_SIGN: begin
        push      = neg && !fifo_status.full;
        push_data = '{strobe: 1'b1, rs: 1'b1, data: lcdws_pkg::ASCII_MINUS,
                      err: 1'b0, last: 1'b0};
      end
      S_DIG: begin
        push      = !fifo_status.full;
        push_data = '{strobe: 1'b1, rs: 1'b1,
                      data: lcdws_pkg::ASCII_ZERO + {4'b0, digits[idx]},
                      err: 1'b0, last: (idx == '0)};
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ndig  <= '0;
      idx   <= '0;
      neg   <= 1'b0;
      mag   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && (item.kind == lcdws_pkg::KIND_NUMBER)) begin
            neg   <= raw[15];
            mag   <= raw[15] ? (16'd0 - raw) : raw;
            ndig  <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          digits[ndig] <= rem[3:0];
          ndig         <= ndig + 1'b1;
          mag          <= quot;
          if ((quot == 16'd0) || (ndig == lcdws_pkg::DIGIT_IW'(lcdws_pkg::MAX_DIGITS - 1))) begin
            state <= S_SIGN;
          end
        end
        S_SIGN: begin
          if (!neg || !fifo_status.full) begin
            idx   <= ndig - 1'b1;
            state <= S_DIG;
          end
        end
        S_DIG: begin
          if (!fifo_status.full) begin
            if (idx == '0) begin
              state <= S_IDLE;
            end else begin
              idx <= idx - 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/lcdws_back.sv
// ----------------------------------------------------------------------------
// lcdws_back
// Drains queued bytes, one bus or nibble strobe per cycle when any are queued.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdws_back (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    four_bit_mode,
  input  wire lcdws_pkg::fifo_status_t fifo_status,
  input  wire lcdws_pkg::byte_entry_t  head,
  output logic                         pop,
  output logic                         result_strobe,
  output lcdws_pkg::result_t           result
);

  logic              phase;
  logic              split_high;
  lcdws_pkg::result_t result_next;

  // In 4-bit mode a byte stays at the head while its high nibble goes out.
  assign split_high = four_bit_mode && head.strobe && !phase;
  assign pop        = !fifo_status.empty && !split_high;

  always_comb begin
    result_next.strobe_res      = head.strobe;
    result_next.register_select = head.rs;
    result_next.range_error     = head.err;
    if (!head.strobe) begin
      result_next.bus_data = 8'd0;
      result_next.last     = head.last;
    end else if (split_high) begin
      result_next.bus_data = {4'b0, head.data[7:4]};
      result_next.last     = 1'b0;
    end else if (four_bit_mode) begin
      result_next.bus_data = {4'b0, head.data[3:0]};
      result_next.last     = head.last;
    end else begin
      result_next.bus_data = head.data;
      result_next.last     = head.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
      phase         <= 1'b0;
    end else begin
      result_strobe <= !fifo_status.empty;
      if (!fifo_status.empty) begin
        phase <= split_high;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!fifo_status.empty) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/char_lcd_write_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_write_sequencer
// Turns character LCD requests into register select and data bus strobes.
// ----------------------------------------------------------------------------
// A byte request is written into the queue and then into the registered
// result of the back end; a number first passes the divide state, once per
// decimal digit (up to five), and then the sign state. The back end gives
// one result per cycle while the queue holds an entry, a high and a low
// nibble per byte in 4-bit mode (12 results at most for "-32768"); busy
// stays high while a number is converted or sent and while the queue is full.
// Synchronous reset clears the queue, control state and config registers.
`default_nettype none

module char_lcd_write_sequencer (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire lcdws_pkg::item_t  item,
  output logic                   busy,
  output logic                   result_strobe,
  output lcdws_pkg::result_t     result,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic       four_bit_mode;
  logic [7:0] line_one_base;
  logic [7:0] line_two_base;
  logic       cfg_write;

  logic                    push;
  logic                    pop;
  lcdws_pkg::byte_entry_t  push_data;
  lcdws_pkg::byte_entry_t  head;
  lcdws_pkg::fifo_status_t fifo_status;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      four_bit_mode <= 1'b0;
      line_one_base <= lcdws_pkg::LINE_ONE_BASE_RESET;
      line_two_base <= lcdws_pkg::LINE_TWO_BASE_RESET;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        lcdws_pkg::REG_FOUR_BIT_MODE: four_bit_mode <= pwdata[0];
        lcdws_pkg::REG_LINE_ONE_BASE: line_one_base <= pwdata[7:0];
        lcdws_pkg::REG_LINE_TWO_BASE: line_two_base <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      lcdws_pkg::REG_FOUR_BIT_MODE: prdata = {31'b0, four_bit_mode};
      lcdws_pkg::REG_LINE_ONE_BASE: prdata = {24'b0, line_one_base};
      lcdws_pkg::REG_LINE_TWO_BASE: prdata = {24'b0, line_two_base};
      default:                      prdata = 32'b0;
    endcase
  end

  lcdws_front u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .item          (item),
    .line_one_base (line_one_base),
    .line_two_base (line_two_base),
    .fifo_status   (fifo_status),
    .busy          (busy),
    .push          (push),
    .push_data     (push_data)
  );

  lcdws_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (fifo_status)
  );

  lcdws_back u_back (
    .clk           (clk),
    .rst           (rst),
    .four_bit_mode (four_bit_mode),
    .fifo_status   (fifo_status),
    .head          (head),
    .pop           (pop),
    .result_strobe (result_strobe),
    .result        (result)
  );

`include "char_lcd_write_sequencer_macros.svh"

  `LCDWS_ASSERT_IMP(a_error_is_status_only, result_strobe && result.range_error, !result.strobe_res && result.last && (result.bus_data == 8'd0), "range error result drove a strobe")
  `LCDWS_ASSERT_IMP(a_nibble_upper_zero, result_strobe && four_bit_mode, result.bus_data[7:4] == 4'd0, "nibble transfer has upper bits set")
  `LCDWS_ASSERT_NEXT(a_number_holds_busy, start && !busy && (item.kind == lcdws_pkg::KIND_NUMBER), busy, "number request did not hold off the next transfer")
  `LCDWS_ASSERT_IMP(a_no_push_when_full, fifo_status.full, !push || pop, "queue overflow")

endmodule

`default_nettype wire
